// ===== rtl/aftm_pkg.sv =====
// ============================================================================
// aftm_pkg
// Shared constants, codes and types for the filmic tonemap pipeline.
// ============================================================================
`default_nettype none

package aftm_pkg;

  localparam int INT_BITS_DEF  = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam int OUT_W  = 17;
  localparam int X16_W  = 20;
  localparam int PROD_W = 38;
  localparam int QUAD_W = 59;
  localparam int IDX_W  = 3;
  localparam int CURVE_STEPS = 16;

  localparam logic [17:0] CO_A = 18'd164495;
  localparam logic [10:0] CO_B = 11'd1966;
  localparam logic [17:0] CO_C = 18'd159252;
  localparam logic [15:0] CO_D = 16'd38666;
  localparam logic [13:0] CO_E = 14'd9175;

  localparam logic [OUT_W-1:0] ONE_OUT = 17'd65536;

  localparam logic [IDX_W-1:0] IDX_BLACK_RED   = 3'd0;
  localparam logic [IDX_W-1:0] IDX_BLACK_GREEN = 3'd1;
  localparam logic [IDX_W-1:0] IDX_BLACK_BLUE  = 3'd2;
  localparam logic [IDX_W-1:0] IDX_WHITE_RED   = 3'd3;
  localparam logic [IDX_W-1:0] IDX_WHITE_GREEN = 3'd4;
  localparam logic [IDX_W-1:0] IDX_WHITE_BLUE  = 3'd5;

  typedef enum logic [1:0] {
    CODE_ZERO,
    CODE_ONE,
    CODE_CALC
  } code_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             degen;
  } lane_res_t;

  function automatic int lane_latency(int val_bits);
    return val_bits + CURVE_STEPS + 5;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aces_filmic_tonemap_rgb_unit.sv =====
// ============================================================================
// aces_filmic_tonemap_rgb_unit
// Filmic tonemap of one linear RGB pixel per transfer to Q1.16 colour.
// ----------------------------------------------------------------------------
// Pixel channel: pixel_valid / pixel_stall with red_in, green_in, blue_in.
// Result channel: result_valid / result_stall with red_out, green_out,
// blue_out and degenerate_range.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; indexes
// 0-2 are black points, 3-5 white points, others are ignored. cfg_ready is
// always high; write only while the pipeline is empty.
// The pipeline depth is set by the bit-per-stage normalising divider and the
// 16-stage curve divider in each of three parallel lanes.
// Throughput: one pixel per cycle while no held result is stalled.
// Reset clears all valid flags and loads black 0 and white 1.0 per channel.
// When the receiver stalls a held result, the whole pipeline freezes and
// pixel_stall is raised until the result transfers.
// ============================================================================
`default_nettype none

module aces_filmic_tonemap_rgb_unit
  import aftm_pkg::*;
#(
  parameter int INT_BITS  = INT_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pixel_valid,
  output logic                               pixel_stall,
  input  wire logic [INT_BITS+FRAC_BITS-1:0] red_in,
  input  wire logic [INT_BITS+FRAC_BITS-1:0] green_in,
  input  wire logic [INT_BITS+FRAC_BITS-1:0] blue_in,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [OUT_W-1:0]                   red_out,
  output logic [OUT_W-1:0]                   green_out,
  output logic [OUT_W-1:0]                   blue_out,
  output logic                               degenerate_range,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [IDX_W-1:0]              cfg_index,
  input  wire logic [INT_BITS+FRAC_BITS-1:0] cfg_data
);

  localparam int VAL = INT_BITS + FRAC_BITS;
  localparam int LAT = lane_latency(VAL);

  logic [VAL-1:0] black_red, black_green, black_blue;
  logic [VAL-1:0] white_red, white_green, white_blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_red   <= '0;
      black_green <= '0;
      black_blue  <= '0;
      white_red   <= VAL'(65536);
      white_green <= VAL'(65536);
      white_blue  <= VAL'(65536);
    end else if (cfg_valid) begin
      case (cfg_index)
        IDX_BLACK_RED:   black_red   <= cfg_data;
        IDX_BLACK_GREEN: black_green <= cfg_data;
        IDX_BLACK_BLUE:  black_blue  <= cfg_data;
        IDX_WHITE_RED:   white_red   <= cfg_data;
        IDX_WHITE_GREEN: white_green <= cfg_data;
        IDX_WHITE_BLUE:  white_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !(result_valid && result_stall);
  assign pixel_stall = !en;

  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pixel_valid};
    end
  end

  lane_res_t res_r, res_g, res_b;

  aftm_lane #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_r (
    .clk(clk), .en(en), .v(red_in), .blk(black_red), .wht(white_red), .res(res_r)
  );

  aftm_lane #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_g (
    .clk(clk), .en(en), .v(green_in), .blk(black_green), .wht(white_green),
    .res(res_g)
  );

  aftm_lane #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_b (
    .clk(clk), .en(en), .v(blue_in), .blk(black_blue), .wht(white_blue),
    .res(res_b)
  );

  aftm_merge u_merge (
    .clk(clk), .rst(rst), .en(en), .vin(vld[LAT-1]),
    .lane_r(res_r), .lane_g(res_g), .lane_b(res_b),
    .vout(result_valid), .red(red_out), .green(green_out), .blue(blue_out),
    .degen(degenerate_range)
  );

  a_stall_follows_out : assert property (@(posedge clk) disable iff (rst)
    pixel_stall == (result_valid && result_stall))
    else $error("pixel stall does not follow held result");

  a_range : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (red_out <= ONE_OUT && green_out <= ONE_OUT && blue_out <= ONE_OUT))
    else $error("result above 1.0");

  a_reset_empty : assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_freeze : assert property (@(posedge clk) disable iff (rst)
    pixel_stall |=> $stable(vld))
    else $error("pipeline advanced while stalled");

endmodule

`default_nettype wire

// ===== rtl/aftm_lane.sv =====
// ============================================================================
// aftm_lane
// One colour channel: normalise against black/white, then the filmic curve,
// all as a fixed-latency pipeline advancing on en.
// ============================================================================
`default_nettype none

module aftm_lane
  import aftm_pkg::*;
#(
  parameter int INT_BITS  = INT_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [INT_BITS+FRAC_BITS-1:0] v,
  input  wire logic [INT_BITS+FRAC_BITS-1:0] blk,
  input  wire logic [INT_BITS+FRAC_BITS-1:0] wht,
  output lane_res_t                          res
);

  localparam int VAL = INT_BITS + FRAC_BITS;

  // normalising divider stages
  code_t            code_d [0:VAL];
  logic             deg_d  [0:VAL];
  logic             sat_d  [0:VAL];
  logic [VAL-1:0]   rem_d  [0:VAL];
  logic [VAL-1:0]   lo_d   [0:VAL];
  logic [VAL-1:0]   quo_d  [0:VAL];
  logic [VAL-1:0]   rng_d  [0:VAL];

  always_ff @(posedge clk) begin
    if (en) begin
      deg_d[0] <= (wht <= blk);
      code_d[0] <= ((wht <= blk) || (v <= blk)) ? CODE_ZERO : CODE_CALC;
      sat_d[0] <= ({{INT_BITS{1'b0}}, v - blk} >= {wht - blk, {INT_BITS{1'b0}}});
      rem_d[0] <= VAL'((v - blk) >> INT_BITS);
      lo_d[0]  <= {(v[INT_BITS-1:0] - blk[INT_BITS-1:0]), {FRAC_BITS{1'b0}}};
      quo_d[0] <= '0;
      rng_d[0] <= wht - blk;
    end
  end

  for (genvar k = 1; k <= VAL; k++) begin : g_ndiv
    logic [VAL:0] rs;
    assign rs = {rem_d[k-1], lo_d[k-1][VAL-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        code_d[k] <= code_d[k-1];
        deg_d[k]  <= deg_d[k-1];
        sat_d[k]  <= sat_d[k-1];
        rng_d[k]  <= rng_d[k-1];
        lo_d[k]   <= {lo_d[k-1][VAL-2:0], 1'b0};
        if (rs >= {1'b0, rng_d[k-1]}) begin
          rem_d[k] <= VAL'(rs - {1'b0, rng_d[k-1]});
          quo_d[k] <= {quo_d[k-1][VAL-2:0], 1'b1};
        end else begin
          rem_d[k] <= rs[VAL-1:0];
          quo_d[k] <= {quo_d[k-1][VAL-2:0], 1'b0};
        end
      end
    end
  end

  // conversion to Q4.16
  logic [VAL-1:0]   x;
  logic [X16_W-1:0] x16;
  assign x = sat_d[VAL] ? {VAL{1'b1}} : quo_d[VAL];

  if (FRAC_BITS >= 16) begin : g_down
    assign x16 = X16_W'(x >> (FRAC_BITS - 16));
  end else begin : g_up
    assign x16 = X16_W'({x, {(16 - FRAC_BITS){1'b0}}});
  end

  code_t            code_c;
  logic             deg_c;
  logic [X16_W-1:0] x16_c;

  always_ff @(posedge clk) begin
    if (en) begin
      deg_c <= deg_d[VAL];
      x16_c <= x16;
      if (code_d[VAL] == CODE_CALC && {1'b0, x} >= ((VAL+1)'(16) << FRAC_BITS))
        code_c <= CODE_ONE;
      else
        code_c <= code_d[VAL];
    end
  end

  // polynomial products
  code_t             code_m1, code_m2;
  logic              deg_m1, deg_m2;
  logic [X16_W-1:0]  x16_m1;
  logic [PROD_W-1:0] pa, pc;
  logic [QUAD_W-1:0] num, den;

  always_ff @(posedge clk) begin
    if (en) begin
      code_m1 <= code_c;
      deg_m1  <= deg_c;
      x16_m1  <= x16_c;
      pa <= PROD_W'(CO_A) * PROD_W'(x16_c) + (PROD_W'(CO_B) << 16);
      pc <= PROD_W'(CO_C) * PROD_W'(x16_c) + (PROD_W'(CO_D) << 16);
      code_m2 <= code_m1;
      deg_m2  <= deg_m1;
      num <= QUAD_W'(x16_m1) * QUAD_W'(pa);
      den <= QUAD_W'(x16_m1) * QUAD_W'(pc) + (QUAD_W'(CO_E) << 32);
    end
  end

  // curve divider stages
  code_t                  code_q [0:CURVE_STEPS];
  logic                   deg_q  [0:CURVE_STEPS];
  logic [QUAD_W-1:0]      rem_q  [0:CURVE_STEPS];
  logic [QUAD_W-1:0]      den_q  [0:CURVE_STEPS];
  logic [CURVE_STEPS-1:0] quo_q  [0:CURVE_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      deg_q[0]  <= deg_m2;
      code_q[0] <= (code_m2 == CODE_CALC && num >= den) ? CODE_ONE : code_m2;
      rem_q[0]  <= num;
      den_q[0]  <= den;
      quo_q[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= CURVE_STEPS; k++) begin : g_cdiv
    logic [QUAD_W:0] rs;
    assign rs = {rem_q[k-1], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        code_q[k] <= code_q[k-1];
        deg_q[k]  <= deg_q[k-1];
        den_q[k]  <= den_q[k-1];
        if (rs >= {1'b0, den_q[k-1]}) begin
          rem_q[k] <= QUAD_W'(rs - {1'b0, den_q[k-1]});
          quo_q[k] <= {quo_q[k-1][CURVE_STEPS-2:0], 1'b1};
        end else begin
          rem_q[k] <= rs[QUAD_W-1:0];
          quo_q[k] <= {quo_q[k-1][CURVE_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    res.degen = deg_q[CURVE_STEPS];
    case (code_q[CURVE_STEPS])
      CODE_ZERO: res.value = '0;
      CODE_ONE:  res.value = ONE_OUT;
      CODE_CALC: res.value = OUT_W'(quo_q[CURVE_STEPS]);
      default:   res.value = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/aftm_merge.sv =====
// ============================================================================
// aftm_merge
// Output register: gathers the three lane results and combines their flags.
// ============================================================================
`default_nettype none

module aftm_merge
  import aftm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             vin,
  input  wire lane_res_t        lane_r,
  input  wire lane_res_t        lane_g,
  input  wire lane_res_t        lane_b,
  output logic                  vout,
  output logic [OUT_W-1:0]      red,
  output logic [OUT_W-1:0]      green,
  output logic [OUT_W-1:0]      blue,
  output logic                  degen
);

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= lane_r.value;
      green <= lane_g.value;
      blue  <= lane_b.value;
      degen <= lane_r.degen | lane_g.degen | lane_b.degen;
    end
  end

endmodule

`default_nettype wire
